/* rtl/dtofu_pkg.sv */
`default_nettype none
package dtofu_pkg;

  localparam int COLUMNS   = 128;
  localparam int PAGES     = 8;
  localparam int POSITIONS = COLUMNS * PAGES;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W = $clog2(POSITIONS);

  localparam int ENTRY_W = 9;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] NIBBLE_HIGH   = 8'hF0;
  localparam logic [7:0] NIBBLE_LOW    = 8'h0F;

  localparam logic [1:0] SLOT_PAGE = 2'd0;
  localparam logic [1:0] SLOT_COLH = 2'd1;
  localparam logic [1:0] SLOT_DATA = 2'd3;

  typedef enum logic [1:0] {
    CMD_SET_PIXEL  = 2'd0,
    CMD_WRITE_BYTE = 2'd1,
    CMD_REFRESH    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

/* rtl/dtofu_ram.sv */
`default_nettype none
module dtofu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/dirty_tracked_oled_frame_updater.sv */
// set_pixel and write_byte: read when taken, written back in the next cycle; no new item is
// taken until the write-back is done. refresh_tick: the frame entry is read when the item is
// taken, and in ST_MODIFY it is loaded into the four-slot output register through the single
// frame memory port pair; 0, 1, 3 or 4 bytes then go out in ST_EMIT, one byte a cycle unless stalled.
// Reset clears control state, then a clearing pass over all COLUMNS*PAGES entries (1024) zeroes the
// frame memory with in_stall high.
`default_nettype none
module dirty_tracked_oled_frame_updater
  import dtofu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  input  wire logic [6:0] column,
  input  wire logic [5:0] row,
  input  wire logic       pixel_on,
  input  wire logic [2:0] page_index,
  input  wire logic [7:0] new_byte,
  input  wire logic [7:0] old_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            is_data,
  output logic            last
);

  state_t state, state_next;

  logic [ADDR_W-1:0] clr_addr;
  logic [COL_W-1:0]  scan_col;
  logic [PAGE_W-1:0] scan_page;
  logic [PAGES-1:0]  page_dirty;

  logic [1:0]        op;
  logic [ADDR_W-1:0] addr;
  logic [PAGE_W-1:0] page;
  logic [2:0]        bit_sel;
  logic              on;
  logic [7:0]        nb;
  logic              diff;

  logic [7:0] emit_q [4];
  logic [1:0] emit_idx;
  logic [1:0] emit_end;

  logic               in_acc;
  logic               out_acc;
  logic [2:0]         item_page;
  logic               item_ok;
  logic [ADDR_W-1:0]  item_addr;
  logic [ADDR_W-1:0]  scan_addr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ram_we;

  logic [7:0] rd_byte;
  logic       rd_dirty;
  logic [7:0] mask;
  logic       pg_dirty;
  logic       col_zero;
  logic       col_last;
  logic [7:0] c8;
  logic       send_page;
  logic       send_byte;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign out_acc   = out_valid && !out_stall;

  assign out_byte = emit_q[emit_idx];
  assign is_data  = (emit_idx == SLOT_DATA);
  assign last     = (emit_idx == emit_end);

  assign item_page = (command == CMD_SET_PIXEL) ? row[5:3] : page_index;
  assign item_ok   = ((command == CMD_SET_PIXEL) || (command == CMD_WRITE_BYTE))
                     && (32'(column) < COLUMNS) && (32'(item_page) < PAGES);
  assign item_addr = ADDR_W'(item_page) * ADDR_W'(COLUMNS) + ADDR_W'(column);
  assign scan_addr = ADDR_W'(scan_page) * ADDR_W'(COLUMNS) + ADDR_W'(scan_col);
  assign ram_raddr = (command == CMD_REFRESH) ? scan_addr : item_addr;

  assign rd_byte   = ram_rdata[7:0];
  assign rd_dirty  = ram_rdata[8];
  assign mask      = 8'(1) << bit_sel;
  assign pg_dirty  = page_dirty[scan_page];
  assign col_zero  = (scan_col == '0);
  assign col_last  = (scan_col == COL_W'(COLUMNS - 1));
  assign c8        = 8'(scan_col);
  assign send_page = col_zero && pg_dirty;
  assign send_byte = pg_dirty && rd_dirty;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = '0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      ST_MODIFY: begin
        ram_we = 1'b1;
        case (op)
          CMD_SET_PIXEL:  ram_wdata = {1'b1, on ? (rd_byte | mask) : (rd_byte & ~mask)};
          CMD_WRITE_BYTE: ram_wdata = {rd_dirty | diff, nb};
          default:        ram_wdata = {1'b0, rd_byte};
        endcase
      end
      default: ;
    endcase
  end

  dtofu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POSITIONS)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(POSITIONS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && ((command == CMD_REFRESH) || item_ok)) begin
          state_next = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (op == CMD_REFRESH && (send_page || send_byte)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_acc && last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      scan_col   <= '0;
      scan_page  <= '0;
      page_dirty <= '0;
      emit_idx   <= '0;
      emit_end   <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == ST_MODIFY) begin
        case (op)
          CMD_SET_PIXEL: begin
            page_dirty[page] <= 1'b1;
          end
          CMD_WRITE_BYTE: begin
            if (diff) begin
              page_dirty[page] <= 1'b1;
            end
          end
          default: begin
            emit_idx <= send_page ? SLOT_PAGE : SLOT_COLH;
            emit_end <= send_byte ? SLOT_DATA : SLOT_PAGE;
            if (col_last) begin
              page_dirty[scan_page] <= 1'b0;
              scan_col              <= '0;
              scan_page             <= (scan_page == PAGE_W'(PAGES - 1)) ? '0
                                       : scan_page + PAGE_W'(1);
            end else begin
              scan_col <= scan_col + COL_W'(1);
            end
          end
        endcase
      end
      if (out_acc && !last) begin
        emit_idx <= emit_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op      <= command;
      addr    <= ram_raddr;
      page    <= PAGE_W'(item_page);
      bit_sel <= row[2:0];
      on      <= pixel_on;
      nb      <= new_byte;
      diff    <= (new_byte != old_byte);
    end
    if (state == ST_MODIFY && op == CMD_REFRESH) begin
      emit_q[0] <= CMD_PAGE_BASE + 8'(scan_page);
      emit_q[1] <= CMD_COL_HIGH | ((c8 & NIBBLE_HIGH) >> 4);
      emit_q[2] <= c8 & NIBBLE_LOW;
      emit_q[3] <= rd_byte;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> emit_idx <= emit_end)
    else $error("emit slot beyond end");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MODIFY && op == CMD_REFRESH) |=> scan_col != $past(scan_col))
    else $error("scan position did not advance");

  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_MODIFY))
    else $error("frame write outside clear or modify");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_data) |-> last)
    else $error("data byte not last of tick");
`endif

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import dtofu_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } link_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = '0;
  logic [6:0] column = '0;
  logic [5:0] row = '0;
  logic       pixel_on = 1'b0;
  logic [2:0] page_index = '0;
  logic [7:0] new_byte = '0;
  logic [7:0] old_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  logic [7:0] frame_model [POSITIONS];
  bit         byte_dirty_model [POSITIONS];
  bit         page_dirty_model [PAGES];
  int         scan_cursor = 0;
  link_byte_t link_bytes_due [$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  sender_steady = 1'b0;
  bit  receiver_steady = 1'b0;

  dirty_tracked_oled_frame_updater u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .column     (column),
    .row        (row),
    .pixel_on   (pixel_on),
    .page_index (page_index),
    .new_byte   (new_byte),
    .old_byte   (old_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .is_data    (is_data),
    .last       (last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < POSITIONS; i++) begin
      frame_model[i] = 8'h00;
      byte_dirty_model[i] = 1'b0;
    end
    for (int p = 0; p < PAGES; p++) page_dirty_model[p] = 1'b0;
  end

  task automatic advance_frame_model(input logic [1:0] cmd_v, input logic [6:0] col_v,
                                     input logic [5:0] row_v, input logic on_v,
                                     input logic [2:0] pg_v, input logic [7:0] nb_v,
                                     input logic [7:0] ob_v);
    int         idx;
    int         p;
    int         c;
    int         n;
    logic [7:0] c8;
    logic [7:0] bit_mask;
    link_byte_t burst [4];
    n = 0;
    case (cmd_v)
      CMD_SET_PIXEL: begin
        p = row_v >> 3;
        if (col_v < COLUMNS && p < PAGES) begin
          idx = p * COLUMNS + col_v;
          bit_mask = 8'd1 << row_v[2:0];
          if (on_v) frame_model[idx] = frame_model[idx] | bit_mask;
          else frame_model[idx] = frame_model[idx] & ~bit_mask;
          byte_dirty_model[idx] = 1'b1;
          page_dirty_model[p] = 1'b1;
        end
      end
      CMD_WRITE_BYTE: begin
        if (col_v < COLUMNS && pg_v < PAGES) begin
          idx = pg_v * COLUMNS + col_v;
          frame_model[idx] = nb_v;
          if (nb_v != ob_v) begin
            byte_dirty_model[idx] = 1'b1;
            page_dirty_model[pg_v] = 1'b1;
          end
        end
      end
      CMD_REFRESH: begin
        p = scan_cursor / COLUMNS;
        c = scan_cursor % COLUMNS;
        c8 = 8'(c);
        if (c == 0 && page_dirty_model[p]) begin
          burst[n] = '{value: CMD_PAGE_BASE + 8'(p), is_data: 1'b0, last: 1'b0};
          n++;
        end
        if (page_dirty_model[p] && byte_dirty_model[scan_cursor]) begin
          burst[n] = '{value: CMD_COL_HIGH | ((c8 & NIBBLE_HIGH) >> 4), is_data: 1'b0,
                       last: 1'b0};
          burst[n + 1] = '{value: c8 & NIBBLE_LOW, is_data: 1'b0, last: 1'b0};
          burst[n + 2] = '{value: frame_model[scan_cursor], is_data: 1'b1, last: 1'b0};
          n += 3;
        end
        byte_dirty_model[scan_cursor] = 1'b0;
        if (c == COLUMNS - 1) page_dirty_model[p] = 1'b0;
        scan_cursor = (scan_cursor + 1) % POSITIONS;
        if (n > 0) burst[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++) link_bytes_due.push_back(burst[k]);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] cmd_v, input logic [6:0] col_v,
                           input logic [5:0] row_v, input logic on_v,
                           input logic [2:0] pg_v, input logic [7:0] nb_v,
                           input logic [7:0] ob_v);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command    <= cmd_v;
    column     <= col_v;
    row        <= row_v;
    pixel_on   <= on_v;
    page_index <= pg_v;
    new_byte   <= nb_v;
    old_byte   <= ob_v;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    advance_frame_model(cmd_v, col_v, row_v, on_v, pg_v, nb_v, ob_v);
  endtask

  task automatic send_tick();
    send_item(CMD_REFRESH, 7'($urandom), 6'($urandom), 1'($urandom), 3'($urandom),
              8'($urandom), 8'($urandom));
  endtask

  task automatic wait_link_idle();
    while (link_bytes_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    link_byte_t want;
    int         hold;
    forever begin
      hold = receiver_steady ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (link_bytes_due.size() == 0) begin
        $error("unexpected item: out_byte %02h is_data %0b last %0b",
               out_byte, is_data, last);
        error_count++;
      end else begin
        want = link_bytes_due.pop_front();
        if (out_byte !== want.value) begin
          $error("out_byte expected %02h actual %02h", want.value, out_byte);
          error_count++;
        end
        if (is_data !== want.is_data) begin
          $error("is_data expected %0b actual %0b", want.is_data, is_data);
          error_count++;
        end
        if (last !== want.last) begin
          $error("last expected %0b actual %0b", want.last, last);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_item(CMD_SET_PIXEL, 7'd0, 6'd0, 1'b1, 3'd7, 8'hFF, 8'hFF);
    send_item(CMD_SET_PIXEL, 7'd127, 6'd63, 1'b1, 3'd0, 8'h00, 8'h00);
    send_item(CMD_SET_PIXEL, 7'd1, 6'd7, 1'b1, 3'd0, 8'h00, 8'hFF);
    send_item(CMD_SET_PIXEL, 7'd1, 6'd7, 1'b0, 3'd0, 8'h00, 8'hFF);
    send_item(CMD_WRITE_BYTE, 7'd2, 6'd63, 1'b0, 3'd0, 8'hFF, 8'h00);
    send_item(CMD_WRITE_BYTE, 7'd3, 6'd0, 1'b1, 3'd0, 8'h5A, 8'h5A);
    send_item(CMD_UNUSED, 7'd127, 6'd63, 1'b1, 3'd7, 8'hFF, 8'h00);
    send_item(CMD_WRITE_BYTE, 7'd127, 6'd0, 1'b0, 3'd7, 8'h00, 8'hFF);
    repeat (4) send_tick();
    send_item(CMD_SET_PIXEL, 7'd0, 6'd3, 1'b1, 3'd0, 8'h00, 8'h00);
    send_item(CMD_WRITE_BYTE, 7'd4, 6'd0, 1'b0, 3'd0, 8'h80, 8'h00);
    send_item(CMD_WRITE_BYTE, 7'd5, 6'd0, 1'b0, 3'd0, 8'h00, 8'h00);
    repeat (2) send_tick();
    send_item(CMD_WRITE_BYTE, 7'd17, 6'd0, 1'b0, 3'd0, 8'h3C, 8'hC3);
    send_item(CMD_REFRESH, 7'd127, 6'd63, 1'b1, 3'd7, 8'hFF, 8'hFF);
    send_item(CMD_REFRESH, 7'd0, 6'd0, 1'b0, 3'd0, 8'h00, 8'h00);
  endtask

  task automatic test_random_refresh_traffic(input int item_count);
    int         target;
    int         pick;
    logic [1:0] cmd_v;
    logic [6:0] col_v;
    logic [5:0] row_v;
    logic [2:0] pg_v;
    logic [7:0] nb_v;
    logic [7:0] ob_v;
    for (int i = 0; i < item_count; i++) begin
      if (i % 48 == 0) begin
        sender_steady = ($urandom_range(0, 3) == 0);
        receiver_steady = ($urandom_range(0, 3) == 0);
      end
      if (i % 4 != 0) begin
        send_tick();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 75) target = (scan_cursor + $urandom_range(0, 12)) % POSITIONS;
        else if (pick < 87) target = (scan_cursor + POSITIONS - $urandom_range(1, 6)) % POSITIONS;
        else target = $urandom_range(0, POSITIONS - 1);
        col_v = 7'(target % COLUMNS);
        pg_v  = 3'(target / COLUMNS);
        row_v = 6'($urandom);
        nb_v  = 8'($urandom);
        ob_v  = ($urandom_range(0, 3) == 0) ? nb_v : 8'($urandom);
        pick  = $urandom_range(0, 99);
        if (pick < 5) begin
          cmd_v = CMD_UNUSED;
        end else if (pick < 50) begin
          cmd_v = CMD_SET_PIXEL;
          row_v = {pg_v, 3'($urandom)};
          pg_v  = 3'($urandom);
        end else begin
          cmd_v = CMD_WRITE_BYTE;
        end
        send_item(cmd_v, col_v, row_v, 1'($urandom), pg_v, nb_v, ob_v);
      end
    end
  endtask

  task automatic test_sender_pause();
    in_valid <= 1'b0;
    wait_link_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_refresh_traffic(170);
    test_sender_pause();
    test_random_refresh_traffic(170);
    in_valid <= 1'b0;
    wait_link_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
